// File: sv/tick_to_nanosecond_muldiv_assert.svh
// Assertion macros shared by the tick-to-nanosecond scaler RTL.
// Depends on nothing; included by modules that carry concurrent checks.
`ifndef TICK_TO_NANOSECOND_MULDIV_ASSERT_SVH
`define TICK_TO_NANOSECOND_MULDIV_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define TNM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define TNM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/tnm_pkg.sv
// Package for the tick-to-nanosecond scaler: widths, reset values,
// register indexes and the divider pipeline word. Depends on nothing.
package tnm_pkg;

  localparam int TICK_W    = 64;
  localparam int COEF_W    = 32;
  localparam int PROD_W    = TICK_W + COEF_W;
  localparam int CFG_IDX_W = 8;

  localparam logic [COEF_W-1:0] MULT_RESET = 32'd1000000000;
  localparam logic [COEF_W-1:0] DIV_RESET  = 32'd10000000;

  localparam logic [CFG_IDX_W-1:0] REG_MULTIPLIER = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIVISOR    = 8'd1;

  // Restoring division: quotient bits resolved per divider stage.
  localparam int DIV_STEPS  = 4;
  localparam int DIV_STAGES = PROD_W / DIV_STEPS;

  // Partial remainder plus dividend bits still to consume, with quotient
  // bits shifted in at the bottom as the dividend bits leave the top.
  typedef struct packed {
    logic [COEF_W-1:0] rem;
    logic [PROD_W-1:0] sh;
  } div_word_t;

endpackage

// File: sv/tnm_tick_if.sv
// Input channel of the scaler: one tick count per transfer.
// Depends on tnm_pkg for the field width.
interface tnm_tick_if;
  logic                       valid;
  logic                       ready;
  logic [tnm_pkg::TICK_W-1:0] tick_count;

  modport source (output valid, output tick_count, input ready);
  modport sink (input valid, input tick_count, output ready);
endinterface

// File: sv/tnm_ns_if.sv
// Result channel of the scaler: one scaled value per transfer.
// Depends on tnm_pkg for the field width.
interface tnm_ns_if;
  logic                       valid;
  logic                       ready;
  logic [tnm_pkg::TICK_W-1:0] scaled_value;

  modport source (output valid, output scaled_value, input ready);
  modport sink (input valid, input scaled_value, output ready);
endinterface

// File: sv/tnm_cfg_if.sv
// Register write channel of the scaler: register index and write data.
// Depends on tnm_pkg for the field widths.
interface tnm_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [tnm_pkg::CFG_IDX_W-1:0] index;
  logic [tnm_pkg::COEF_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: sv/tick_to_nanosecond_muldiv.sv
// Tick-to-nanosecond scaler: top level with registers and pipeline control.
// Depends on tnm_pkg, the three channel interfaces, tnm_div_stage and the
// assertion macro header.
//
// Converts each 64-bit tick count into floor(tick_count * multiplier /
// divisor), keeping the low 64 bits of the quotient so large values wrap.
// The block takes one transfer per clock while the result side keeps up,
// and passes each item through a stage for the two 32x32 partial products,
// a stage for the 96-bit product sum, and then the restoring divider,
// which resolves four quotient bits in each stage over all 96 product
// bits. Every stage holds its own valid bit and loads when it is empty or
// when the stage after it moves, so bubbles close up behind a stalled
// result and nothing is dropped or repeated. The last divider stage
// is the output register. Write multiplier (index 0) and divisor (index 1)
// only while no items are in flight; a divisor write of zero is dropped,
// and writes to any other index do nothing. Write transfers are always
// accepted.
module tick_to_nanosecond_muldiv (
  input  logic      clk,
  input  logic      rst,
  tnm_tick_if.sink  tick,
  tnm_ns_if.source  result,
  tnm_cfg_if.sink   cfg
);
  import tnm_pkg::*;
  `include "tick_to_nanosecond_muldiv_assert.svh"

  localparam int NSTAGES = DIV_STAGES + 2;

  logic [COEF_W-1:0] multiplier;
  logic [COEF_W-1:0] divisor;

  // Stage 0: partial products, stage 1: full product, then the divider.
  logic [NSTAGES-1:0] v;
  logic [NSTAGES-1:0] en;

  // Valid bits of the two multiply stages.
  logic v_part;
  logic v_sum;

  logic [2*COEF_W-1:0] prod_lo;
  logic [2*COEF_W-1:0] prod_hi;
  logic [PROD_W-1:0]   prod;

  div_word_t div_word [DIV_STAGES+1];
  logic      div_valid [DIV_STAGES+1];

  // Register writes: drop a zero divisor, ignore unknown indexes.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      multiplier <= MULT_RESET;
      divisor    <= DIV_RESET;
    end else if (cfg.valid) begin
      if (cfg.index == REG_MULTIPLIER) begin
        multiplier <= cfg.data;
      end else if (cfg.index == REG_DIVISOR && cfg.data != '0) begin
        divisor <= cfg.data;
      end
    end
  end

  // Load enables: a stage advances when empty or when its successor moves.
  assign en[NSTAGES-1] = !v[NSTAGES-1] || result.ready;
  for (genvar i = 0; i < NSTAGES-1; i++) begin : g_en
    assign en[i] = !v[i] || en[i+1];
  end

  assign tick.ready = en[0];

  // Multiply stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      v_part <= 1'b0;
      v_sum  <= 1'b0;
    end else begin
      if (en[0]) begin
        v_part <= tick.valid;
      end
      if (en[1]) begin
        v_sum <= v_part;
      end
    end
  end

  assign v[0] = v_part;
  assign v[1] = v_sum;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      prod_lo <= {{COEF_W{1'b0}}, tick.tick_count[COEF_W-1:0]} *
                 {{COEF_W{1'b0}}, multiplier};
      prod_hi <= {{COEF_W{1'b0}}, tick.tick_count[TICK_W-1:COEF_W]} *
                 {{COEF_W{1'b0}}, multiplier};
    end
    if (en[1]) begin
      prod <= {prod_hi, {COEF_W{1'b0}}} + {{COEF_W{1'b0}}, prod_lo};
    end
  end

  // Divider chain: start with a zero remainder and the whole product.
  assign div_word[0]  = '{rem: '0, sh: prod};
  assign div_valid[0] = v[1];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    tnm_div_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .en        (en[k+2]),
      .in_valid  (div_valid[k]),
      .in_word   (div_word[k]),
      .den       (divisor),
      .out_valid (div_valid[k+1]),
      .out_word  (div_word[k+1])
    );
    assign v[k+2] = div_valid[k+1];
  end

  // Low 64 quotient bits; the upper ones wrap away.
  assign result.valid        = v[NSTAGES-1];
  assign result.scaled_value = div_word[DIV_STAGES].sh[TICK_W-1:0];

  `TNM_ASSERT_NOW(a_divisor_nonzero, clk, rst, 1'b1, divisor != '0, "divisor register holds zero")
  `TNM_ASSERT_NEXT(a_accept_enters, clk, rst, tick.valid && tick.ready, v[0], "accepted item missing from first stage")
  `TNM_ASSERT_NOW(a_stall_only_full, clk, rst, !tick.ready, $countones(v) == NSTAGES, "input stalled with a bubble in the pipeline")

endmodule

// File: sv/tnm_div_stage.sv
// One register stage of the pipelined restoring divider: resolves
// DIV_STEPS quotient bits per stage. Depends on tnm_pkg.
module tnm_div_stage (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  tnm_pkg::div_word_t         in_word,
  input  logic [tnm_pkg::COEF_W-1:0] den,
  output logic                       out_valid,
  output tnm_pkg::div_word_t         out_word
);
  import tnm_pkg::*;

  div_word_t word_next;

  always_comb begin
    div_word_t         w;
    logic [COEF_W:0]   r_ext;
    logic [COEF_W:0]   d_ext;
    logic [COEF_W:0]   diff;
    logic              ge;
    w     = in_word;
    d_ext = {1'b0, den};
    for (int j = 0; j < DIV_STEPS; j++) begin
      r_ext = {w.rem, w.sh[PROD_W-1]};
      ge    = (r_ext >= d_ext);
      diff  = r_ext - d_ext;
      w.rem = ge ? diff[COEF_W-1:0] : r_ext[COEF_W-1:0];
      w.sh  = {w.sh[PROD_W-2:0], ge};
    end
    word_next = w;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (en) begin
      out_word <= word_next;
    end
  end

endmodule

// File: tb/sv/tick_to_nanosecond_muldiv_tb.sv
// Self-checking testbench for the tick-to-nanosecond scaler.
// Depends on tnm_pkg, the tick, result and register-write channel interfaces
// and the tick_to_nanosecond_muldiv top level.

// Expected scaled values, worked out from a private copy of both registers.
class ns_scoreboard;
  logic [tnm_pkg::COEF_W-1:0] multiplier;
  logic [tnm_pkg::COEF_W-1:0] divisor;
  logic [tnm_pkg::TICK_W-1:0] pending_ns[$];
  int                         mismatches;

  function new();
    multiplier = tnm_pkg::MULT_RESET;
    divisor    = tnm_pkg::DIV_RESET;
    mismatches = 0;
  endfunction

  // Mirror a register write; a zero divisor and unknown indexes are dropped.
  function void write_register(logic [tnm_pkg::CFG_IDX_W-1:0] idx,
                               logic [tnm_pkg::COEF_W-1:0] data);
    if (idx == tnm_pkg::REG_MULTIPLIER) begin
      multiplier = data;
    end else if (idx == tnm_pkg::REG_DIVISOR && data != '0) begin
      divisor = data;
    end
  endfunction

  // Full 96-bit product, floor division, low 64 bits of the quotient kept.
  function logic [tnm_pkg::TICK_W-1:0] ticks_to_ns(logic [tnm_pkg::TICK_W-1:0] ticks);
    logic [tnm_pkg::PROD_W-1:0] product;
    logic [tnm_pkg::PROD_W-1:0] quotient;
    product  = {{tnm_pkg::COEF_W{1'b0}}, ticks} * {{tnm_pkg::TICK_W{1'b0}}, multiplier};
    quotient = product / {{tnm_pkg::TICK_W{1'b0}}, divisor};
    return quotient[tnm_pkg::TICK_W-1:0];
  endfunction

  function void note_tick(logic [tnm_pkg::TICK_W-1:0] ticks);
    pending_ns.push_back(ticks_to_ns(ticks));
  endfunction

  function void check_result(logic [tnm_pkg::TICK_W-1:0] actual);
    logic [tnm_pkg::TICK_W-1:0] expected;
    if (pending_ns.size() == 0) begin
      $error("scaled_value: no result expected, actual %0d", actual);
      mismatches++;
    end else begin
      expected = pending_ns.pop_front();
      if (actual !== expected) begin
        $error("scaled_value mismatch: expected %0d, actual %0d", expected, actual);
        mismatches++;
      end
    end
  endfunction
endclass

module tick_to_nanosecond_muldiv_tb;
  import tnm_pkg::*;

  // An index that maps to no register; writes to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 8'hA5;
  localparam logic [COEF_W-1:0]    COEF_MAX     = 32'hFFFF_FFFF;
  localparam logic [TICK_W-1:0]    TICK_MAX     = 64'hFFFF_FFFF_FFFF_FFFF;
  // Random phases and the tick transfers sent in each.
  localparam int RAND_PHASES     = 12;
  localparam int TICKS_PER_PHASE = 67;
  // Stall length that overfills the 26-deep pipeline several times over.
  localparam int LONG_HOLD       = 150;
  // Cycles to let pass after the last result, a little beyond the latency.
  localparam int SETTLE_CYCLES   = 40;

  logic clk;
  logic rst;

  tnm_tick_if tick_ch ();
  tnm_ns_if   ns_ch ();
  tnm_cfg_if  cfg_ch ();

  tick_to_nanosecond_muldiv dut (
    .clk    (clk),
    .rst    (rst),
    .tick   (tick_ch),
    .result (ns_ch),
    .cfg    (cfg_ch)
  );

  ns_scoreboard sb;

  // Idle percentages for both sides, and a pending receiver hold-off.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int recv_hold_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop well beyond the slowest correct run.
  initial begin
    #3000000;
    $display("simulation failed");
    $finish;
  end

  // Observe every transfer at the edge where it happens. The testbench and
  // the block both update with nonblocking assignments, so the values seen
  // here are the ones from before the edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        sb.write_register(cfg_ch.index, cfg_ch.data);
      end
      if (tick_ch.valid && tick_ch.ready) begin
        sb.note_tick(tick_ch.tick_count);
      end
      if (ns_ch.valid && ns_ch.ready) begin
        sb.check_result(ns_ch.scaled_value);
      end
    end
  end

  // Result side: random back-pressure, plus a long hold-off on request.
  // The hold is counted here so that the sender keeps offering meanwhile.
  initial begin
    int hold_len;
    ns_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (recv_hold_cycles > 0) begin
        hold_len = recv_hold_cycles;
        recv_hold_cycles = 0;
        ns_ch.ready <= 1'b0;
        repeat (hold_len) @(posedge clk);
      end
      ns_ch.ready <= !rst && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Offer one tick count and wait for its transfer. Valid is left high on
  // return so that a following item goes out back to back; drop it with
  // tick_stop once a batch is done.
  task automatic send_tick(input logic [TICK_W-1:0] ticks);
    while ($urandom_range(99) < send_idle_pct) begin
      tick_ch.valid <= 1'b0;
      @(posedge clk);
    end
    tick_ch.valid      <= 1'b1;
    tick_ch.tick_count <= ticks;
    @(posedge clk);
    while (!tick_ch.ready) @(posedge clk);
  endtask

  task automatic tick_stop();
    tick_ch.valid <= 1'b0;
  endtask

  // One register write; valid is dropped for a cycle afterwards.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Hold the sender until every expected result is back, then let the
  // last result transfer settle before touching the registers. First let the
  // clock advance so that the last tick transfer has been noted.
  task automatic wait_drained();
    @(posedge clk);
    while (sb.pending_ns.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Mix of full-width, small, 32-bit and shifted counts.
  function automatic logic [TICK_W-1:0] rand_ticks();
    logic [TICK_W-1:0] full;
    full = {$urandom, $urandom};
    case ($urandom_range(4))
      0:       return TICK_W'($urandom_range(0, 1000));
      1:       return TICK_W'($urandom);
      2:       return full >> $urandom_range(63);
      default: return full;
    endcase
  endfunction

  // Register values weighted towards the extremes; zero is allowed, which
  // for the divisor means a write that must be ignored.
  function automatic logic [COEF_W-1:0] rand_coef();
    case ($urandom_range(7))
      0:       return '0;
      1:       return COEF_MAX;
      2:       return 32'd1;
      3:       return COEF_W'($urandom_range(2, 1000));
      4:       return MULT_RESET;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    sb = new();
    rst            <= 1'b1;
    tick_ch.valid  <= 1'b0;
    tick_ch.tick_count <= '0;
    cfg_ch.valid   <= 1'b0;
    cfg_ch.index   <= '0;
    cfg_ch.data    <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at the reset setting: field extremes and the wrap.
    send_tick('0);
    send_tick(64'd1);
    send_tick(64'd99999);
    send_tick(64'h0000_0000_FFFF_FFFF);
    send_tick(64'h0000_0001_0000_0000);
    send_tick(64'h8000_0000_0000_0000);
    send_tick(64'h5555_5555_AAAA_AAAA);
    send_tick(TICK_MAX);
    tick_stop();
    wait_drained();

    // Largest multiplier over a unit divisor: the quotient overflows.
    write_reg(REG_MULTIPLIER, COEF_MAX);
    write_reg(REG_DIVISOR, 32'd1);
    send_tick(TICK_MAX);
    send_tick(64'd1);
    send_tick(64'h0000_0001_0000_0000);
    send_tick(64'hAAAA_AAAA_5555_5555);
    tick_stop();
    wait_drained();

    // Zero multiplier: every result is zero.
    write_reg(REG_MULTIPLIER, '0);
    send_tick(TICK_MAX);
    send_tick(64'h1234_5678_9ABC_DEF0);
    tick_stop();
    wait_drained();

    // A zero divisor write and an unmapped write must both leave the
    // registers alone; the items check that the unit divisor still holds.
    write_reg(REG_MULTIPLIER, COEF_MAX);
    write_reg(REG_DIVISOR, '0);
    write_reg(REG_UNMAPPED, 32'h0BAD_F00D);
    send_tick(TICK_MAX);
    send_tick(64'h0000_0000_8000_0001);
    tick_stop();
    wait_drained();

    // Both registers at their maximum, then a unit multiplier that truncates to 0.
    write_reg(REG_DIVISOR, COEF_MAX);
    send_tick(TICK_MAX);
    send_tick(64'hFEDC_BA98_7654_3210);
    tick_stop();
    wait_drained();
    write_reg(REG_MULTIPLIER, 32'd1);
    send_tick(64'h0000_0000_FFFF_FFFE);
    send_tick(TICK_MAX);
    tick_stop();
    wait_drained();

    // Random phases: new register values at each, idling patterns in turn.
    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      if (phase < RAND_PHASES / 3) begin
        send_idle_pct = 38;
        recv_idle_pct = 82;
      end else if (phase < 2 * RAND_PHASES / 3) begin
        send_idle_pct = 82;
        recv_idle_pct = 38;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_reg(REG_MULTIPLIER, rand_coef());
      write_reg(REG_DIVISOR, rand_coef());
      if ($urandom_range(3) == 0) begin
        write_reg(REG_UNMAPPED, $urandom);
      end
      // Stall the result side for a long stretch while items keep coming,
      // so the pipeline fills and pushes back on the input.
      if (phase == RAND_PHASES - 2) begin
        recv_hold_cycles = LONG_HOLD;
      end
      for (int n = 0; n < TICKS_PER_PHASE; n++) begin
        send_tick(rand_ticks());
      end
      tick_stop();
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_ns.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+sv
sv/tnm_pkg.sv
sv/tnm_tick_if.sv
sv/tnm_ns_if.sv
sv/tnm_cfg_if.sv
sv/tnm_div_stage.sv
sv/tick_to_nanosecond_muldiv.sv
tb/sv/tick_to_nanosecond_muldiv_tb.sv
